// File: hw/rtl/hpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpe_pkg: shared types and constants of the Horner polynomial evaluator
// Request and response payloads, action codes and the control/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package hpe_pkg;

	// Word format: signed Q16.16 by default, fraction width is a top parameter
	localparam int WORD_W  = 32;
	localparam int ORDER_W = 4;
	localparam int INDEX_W = 4;

	// Request actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;

	typedef struct packed {
		logic                      action;
		logic [INDEX_W-1:0]        coef_index;
		logic signed [WORD_W-1:0]  coef_value;
		logic signed [WORD_W-1:0]  x_value;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0]  y_value;
		logic                      saturated;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic wr_en;     // write request coefficient into the table
		logic start;     // capture x, clear saturation flag
		logic load_v;    // running value takes the top coefficient
		logic mul;       // form x * running value, capture coefficient
		logic add;       // add coefficient, saturate into running value
		logic out_load;  // move the result into the response register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_busy;  // response register full and not taken this cycle
	} sts_t;

endpackage

// File: hw/rtl/horner_poly_eval_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// horner_poly_eval_top: Horner polynomial evaluator, signed fixed point
// Load requests fill a coefficient table; evaluate requests return
// y = c[0] + c[1]*x + ... + c[n]*x^n with per-step truncation and saturation.
// ----------------------------------------------------------------------------
// A load request returns nothing. Evaluate requests are taken one at a time:
// the accepting state reads the top coefficient, a load state takes it as the
// running value, then each Horner step has a multiply state (a registered
// 32x32 multiply) and an add state (truncate, add and saturate), then a final
// state hands the result to the response register; that last state repeats
// while the previous result still waits there. The shared multiplier and the
// single table read port serve every step. The request side, for loads and
// evaluations alike, is taken again as soon as the result sits in the response
// register, even if it has not yet been taken.
// The degree register is clamped to DEGREE_MAX; coefficient writes to an index
// above DEGREE_MAX are dropped. Every coefficient up to the degree must be
// written before an evaluation reads it.
module horner_poly_eval_top #(
	parameter int DEGREE_MAX = 15,
	parameter int FRAC_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  hpe_pkg::req_t               req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output hpe_pkg::rsp_t               rsp_data,
	input  logic                        cfg_we,
	input  logic [hpe_pkg::ORDER_W-1:0] cfg_data
);
	import hpe_pkg::*;

	localparam int AW = $clog2(DEGREE_MAX + 1);

	cmd_t          cmd;
	sts_t          sts;
	logic [AW-1:0] rd_addr;

	hpe_ctrl #(
		.DEGREE_MAX (DEGREE_MAX)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.sts       (sts),
		.cmd       (cmd),
		.rd_addr   (rd_addr)
	);

	hpe_dpath #(
		.DEGREE_MAX (DEGREE_MAX),
		.FRAC_BITS  (FRAC_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

// File: hw/rtl/hpe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpe_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/hpe_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpe_dpath: Horner datapath
// Coefficient table, x and running value registers, the registered
// multiplier, the truncate/add/saturate step and the response register.
// ----------------------------------------------------------------------------
module hpe_dpath #(
	parameter int DEGREE_MAX = 15,
	parameter int FRAC_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hpe_pkg::req_t                   req_data,
	input  hpe_pkg::cmd_t                   cmd,
	input  logic [$clog2(DEGREE_MAX+1)-1:0] rd_addr,
	output hpe_pkg::sts_t                   sts,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output hpe_pkg::rsp_t                   rsp_data
);
	import hpe_pkg::*;

	localparam int DEPTH  = DEGREE_MAX + 1;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = (AW > INDEX_W) ? AW : INDEX_W;
	localparam int PROD_W = 2 * WORD_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int TOP_W  = SUM_W - WORD_W + 1;

	logic [WORD_W-1:0]        coef_rd;
	logic [CW-1:0]            widx;
	logic signed [WORD_W-1:0] x_q;
	logic signed [WORD_W-1:0] v_q;
	logic signed [WORD_W-1:0] coef_q;
	logic                     sat_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] prod_tr;
	logic [SUM_W-1:0]         sum;
	logic [TOP_W-1:0]         sum_top;
	logic                     fits;
	logic [WORD_W-1:0]        step_val;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;

	// Coefficient table; controller has already range-checked the index
	assign widx = CW'(req_data.coef_index);

	hpe_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (widx[AW-1:0]),
		.wdata (req_data.coef_value),
		.raddr (rd_addr),
		.rdata (coef_rd)
	);

	// Truncate toward minus infinity, add coefficient exactly, saturate
	always_comb begin
		prod_tr  = prod_s1 >>> FRAC_BITS;
		sum      = {{2{prod_tr[PROD_W-1]}}, prod_tr}
		         + {{(SUM_W-WORD_W){coef_q[WORD_W-1]}}, coef_q};
		sum_top  = sum[SUM_W-1:WORD_W-1];
		fits     = (&sum_top) | ~(|sum_top);
		if (fits) begin
			step_val = sum[WORD_W-1:0];
		end else if (sum[SUM_W-1]) begin
			step_val = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			step_val = {1'b0, {(WORD_W-1){1'b1}}};
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= req_data.x_value;
		end
		if (cmd.mul) begin
			prod_s1 <= x_q * v_q;
			coef_q  <= coef_rd;
		end
		if (cmd.load_v) begin
			v_q <= coef_rd;
		end else if (cmd.add) begin
			v_q <= step_val;
		end
	end

	// Sticky saturation flag for the current evaluation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.start) begin
			sat_q <= 1'b0;
		end else if (cmd.add && !fits) begin
			sat_q <= 1'b1;
		end
	end

	// Response register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.y_value   <= v_q;
			rsp_q.saturated <= sat_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign rsp_data     = rsp_q;
	assign sts.out_busy = rsp_valid_q && !rsp_ready;

endmodule

// File: hw/rtl/hpe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpe_ctrl: Horner controller
// Holds the order register, accepts requests, counts the coefficient index
// down and sequences the datapath through load, multiply and add steps.
// ----------------------------------------------------------------------------
module hpe_ctrl #(
	parameter int DEGREE_MAX = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  hpe_pkg::req_t                   req_data,
	input  logic                            cfg_we,
	input  logic [hpe_pkg::ORDER_W-1:0]     cfg_data,
	input  hpe_pkg::sts_t                   sts,
	output hpe_pkg::cmd_t                   cmd,
	output logic [$clog2(DEGREE_MAX+1)-1:0] rd_addr
);
	import hpe_pkg::*;

	localparam int AW  = $clog2(DEGREE_MAX + 1);
	localparam int CW0 = (AW > ORDER_W) ? AW : ORDER_W;
	localparam int CW  = (CW0 > INDEX_W) ? CW0 : INDEX_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_ADD  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]         state_q;
	logic [2:0]         state_d;
	logic [ORDER_W-1:0] order_q;
	logic [AW-1:0]      k_q;
	logic [AW-1:0]      k_d;
	logic [CW-1:0]      max_ext;
	logic [CW-1:0]      order_ext;
	logic [CW-1:0]      order_clamp;
	logic [CW-1:0]      idx_ext;
	logic               accept;
	logic               eval_go;

	// Clamp the degree to the table size
	always_comb begin
		max_ext     = CW'(DEGREE_MAX);
		order_ext   = CW'(order_q);
		idx_ext     = CW'(req_data.coef_index);
		order_clamp = (order_ext > max_ext) ? max_ext : order_ext;
	end

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign eval_go   = accept && (req_data.action == ACT_EVAL);

	// Next state, commands and read address
	always_comb begin
		state_d      = state_q;
		k_d          = k_q;
		rd_addr      = k_q;
		cmd          = '0;
		cmd.wr_en    = accept && (req_data.action == ACT_LOAD) && (idx_ext <= max_ext);
		case (state_q)
			S_IDLE: begin
				rd_addr = order_clamp[AW-1:0];
				if (eval_go) begin
					cmd.start = 1'b1;
					k_d       = order_clamp[AW-1:0];
					state_d   = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load_v = 1'b1;
				rd_addr    = k_q - 1'b1;
				if (k_q == '0) begin
					state_d = S_FIN;
				end else begin
					k_d     = k_q - 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				rd_addr = k_q - 1'b1;
				if (k_q == '0) begin
					state_d = S_FIN;
				end else begin
					k_d     = k_q - 1'b1;
					state_d = S_MUL;
				end
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state and index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	// Order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= '0;
		end else if (cfg_we) begin
			order_q <= cfg_data;
		end
	end

`ifndef SYNTHESIS
	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("response register overwritten while full");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (CW'(k_q) <= max_ext))
		else $error("coefficient index beyond table");

	a_eval_starts: assert property (@(posedge clk) disable iff (!arst_n)
		eval_go |=> (state_q == S_LOAD))
		else $error("evaluate request did not start the sequence");

	a_mul_then_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |=> (state_q == S_ADD))
		else $error("multiply step not followed by add step");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.wr_en)
		else $error("table write during evaluation");
`endif

endmodule

// File: tb/tb_horner_poly_eval_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_horner_poly_eval_top: self-checking bench for the Horner evaluator
// A short table of directed requests (order zero and one short cuts, word
// extremes, saturation both ways) runs first, then random phases at several
// degrees. Evaluate results are checked against typed row values or a
// fixed-point Horner predictor. Sender bursts and receiver stalls vary throughout the run.
// ----------------------------------------------------------------------------
module tb_horner_poly_eval_top;
	import hpe_pkg::*;

	localparam int DEGREE_MAX       = 15;
	localparam int FRAC_BITS        = 16;
	localparam int NUM_PHASES       = 12;
	localparam int PHASE_ITEMS      = 136;
	localparam int SETTLE_CYCLES    = 40;
	localparam int RUN_LIMIT        = 600000;
	localparam int MAX_REPORTS      = 10;
	localparam int LONG_HOLD_AT     = 250;
	localparam int LONG_HOLD_CYCLES = 500;

	typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_EVAL} row_kind_e;
	typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_e;

	// One directed row: degree write, coefficient load or evaluation
	typedef struct packed {
		row_kind_e          kind;
		logic [3:0]         sel;    // degree or coefficient index
		logic [WORD_W-1:0]  word;   // coefficient or x
		logic               typed;  // expected value given below
		logic [WORD_W-1:0]  y;
		logic               sat;
	} dir_row_t;

	localparam int NUM_DIR = 24;
	localparam dir_row_t DIR_VEC [NUM_DIR] = '{
		'{ROW_CFG,  4'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_LOAD, 4'd0, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, 4'd0, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF, 1'b0},
		'{ROW_LOAD, 4'd0, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, 4'd0, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b0},
		'{ROW_CFG,  4'd1, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_LOAD, 4'd1, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_LOAD, 4'd0, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, 4'd0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1},
		'{ROW_LOAD, 4'd0, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, 4'd0, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1},
		'{ROW_EVAL, 4'd0, 32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0},
		'{ROW_LOAD, 4'd1, 32'h0000_8000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_LOAD, 4'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, 4'd0, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, 4'd0, 32'h0001_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_LOAD, 4'd1, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, 4'd0, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_CFG,  4'd2, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_LOAD, 4'd2, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_LOAD, 4'd1, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_LOAD, 4'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, 4'd0, 32'h0000_0002, 1'b0, 32'h0000_0000, 1'b0},
		'{ROW_EVAL, 4'd0, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0}
	};

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req_data  = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp_data;
	logic               cfg_we    = 1'b0;
	logic [ORDER_W-1:0] cfg_data  = '0;

	// Shadow copy of the coefficient table and degree
	logic signed [WORD_W-1:0] coef_shadow [0:DEGREE_MAX];
	logic [DEGREE_MAX:0]      coef_written = '0;
	logic [ORDER_W-1:0]       order_shadow = '0;

	rsp_t pending_y_q [$];
	int   mismatch_count = 0;
	int   rsp_seen       = 0;
	int   cycle_count    = 0;
	int   burst_left     = 0;

	horner_poly_eval_top #(
		.DEGREE_MAX(DEGREE_MAX),
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Evaluate c[n] .. c[0] at x: truncating product, exact add, saturate
	function automatic rsp_t horner_predict(logic signed [WORD_W-1:0] x);
		logic signed [63:0]       xw, vw, cw, acc;
		logic signed [WORD_W-1:0] v;
		logic                     hit;
		rsp_t                     r;
		int                       k;
		v = coef_shadow[order_shadow];
		hit = 1'b0;
		xw = x;
		for (k = int'(order_shadow) - 1; k >= 0; k--) begin
			vw = v;
			cw = coef_shadow[k];
			acc = ((xw * vw) >>> FRAC_BITS) + cw;
			if (acc > 64'sh0000_0000_7FFF_FFFF) begin
				v = 32'h7FFF_FFFF;
				hit = 1'b1;
			end else if (acc < 64'shFFFF_FFFF_8000_0000) begin
				v = 32'h8000_0000;
				hit = 1'b1;
			end else begin
				v = acc[WORD_W-1:0];
			end
		end
		r.y_value = v;
		r.saturated = hit;
		return r;
	endfunction

	// Mix of full-range, extreme and modest Q16.16 words
	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] w;
		case ($urandom_range(0, 7))
			0: w = $urandom;
			1: begin
				case ($urandom_range(0, 5))
					0: w = 32'h7FFF_FFFF;
					1: w = 32'h8000_0000;
					2: w = 32'h0000_0000;
					3: w = 32'hFFFF_FFFF;
					4: w = 32'h0001_0000;
					default: w = 32'hFFFF_0000;
				endcase
			end
			2, 3: w = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
			default: w = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
		endcase
		return w;
	endfunction

	task automatic flag_result(string what, rsp_t want, rsp_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: %s: expected y=%h sat=%b, got y=%h sat=%b", $time, what,
				want.y_value, want.saturated, got.y_value, got.saturated);
	endtask

	// Offer one request in the current burst, hold it until taken
	task automatic issue_request(req_t r, logic typed, rsp_t typed_rsp);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (!req_ready);
		if (r.action == ACT_LOAD) begin
			if (r.coef_index <= DEGREE_MAX) begin
				coef_shadow[r.coef_index] = r.coef_value;
				coef_written[r.coef_index] = 1'b1;
			end
		end else begin
			pending_y_q.push_back(typed ? typed_rsp : horner_predict(r.x_value));
		end
	endtask

	// Drop valid, wait out all results and the tail of any load
	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_y_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_poly_order(logic [ORDER_W-1:0] ord);
		drain_results();
		cfg_we <= 1'b1;
		cfg_data <= ord;
		@(posedge clk);
		cfg_we <= 1'b0;
		order_shadow = ord;
	endtask

	// Check each taken result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_seen++;
			if (pending_y_q.size() == 0)
				flag_result("result with nothing pending", '0, rsp_data);
			else if (rsp_data !== pending_y_q[0])
				flag_result("result mismatch", pending_y_q.pop_front(), rsp_data);
			else
				void'(pending_y_q.pop_front());
		end
	end

	// Receiver: segments of open, half and sparse ready, one long hold-off
	initial begin
		int       seg_left;
		rx_mode_e mode;
		logic     held;
		seg_left = 0;
		mode = RX_OPEN;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && rsp_seen >= LONG_HOLD_AT) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			if (seg_left == 0) begin
				seg_left = $urandom_range(8, 64);
				mode = rx_mode_e'($urandom_range(0, 2));
			end
			seg_left--;
			case (mode)
				RX_OPEN: rsp_ready <= 1'b1;
				RX_HALF: rsp_ready <= 1'($urandom_range(0, 1));
				default: rsp_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Hard stop on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("tb_horner_poly_eval_top: FAIL");
			$finish;
		end
	end

	initial begin
		dir_row_t           row;
		req_t               r;
		rsp_t               typed_rsp;
		logic [ORDER_W-1:0] ord;
		int                 missing;
		int                 ph, n, k;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (k = 0; k < NUM_DIR; k++) begin
			row = DIR_VEC[k];
			if (row.kind == ROW_CFG) begin
				set_poly_order(row.sel);
			end else begin
				r.action = (row.kind == ROW_EVAL) ? ACT_EVAL : ACT_LOAD;
				r.coef_index = row.sel;
				r.coef_value = row.word;
				r.x_value = row.word;
				typed_rsp.y_value = row.y;
				typed_rsp.saturated = row.sat;
				issue_request(r, row.typed, typed_rsp);
			end
		end

		// Random phases, each at its own degree
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: ord = 4'd15;
				1: ord = 4'd0;
				NUM_PHASES - 1: ord = 4'd15;
				default: ord = ORDER_W'($urandom_range(0, DEGREE_MAX));
			endcase
			set_poly_order(ord);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				missing = -1;
				for (k = 0; k <= int'(ord); k++)
					if (!coef_written[k] && missing < 0)
						missing = k;
				r.coef_index = INDEX_W'($urandom_range(0, 15));
				r.coef_value = pick_word();
				r.x_value = pick_word();
				// Fill any coefficient the degree needs before evaluating
				if (missing >= 0) begin
					r.action = ACT_LOAD;
					r.coef_index = INDEX_W'(missing);
				end else if ($urandom_range(0, 1) == 1) begin
					r.action = ACT_EVAL;
				end else begin
					r.action = ACT_LOAD;
					if ($urandom_range(0, 3) != 0)
						r.coef_index = INDEX_W'($urandom_range(0, int'(ord)));
				end
				issue_request(r, 1'b0, '0);
			end
		end

		drain_results();
		if (mismatch_count == 0)
			$display("tb_horner_poly_eval_top: PASS");
		else
			$display("tb_horner_poly_eval_top: FAIL");
		$finish;
	end

endmodule
